[rtl/npe_pkg.sv]
// Shared types and constants for the equirectangular nearest-point block.
`timescale 1ns / 1ps
package npe_pkg;

  // Field widths
  localparam int LON_W  = 29;
  localparam int LAT_W  = 28;
  localparam int POS_W  = 16;
  localparam int DIST_W = 26;
  localparam int SQ_W   = 48;
  localparam int COS_W  = 17;
  localparam int T_W    = 21;
  localparam int ROOT_W = 64;

  // Defaults for top-level parameters
  localparam int MAX_POINTS_DEF        = 65536;
  localparam int COS_TABLE_ENTRIES_DEF = 1024;
  localparam int QUEUE_DEPTH           = 2;

  // Arithmetic constants
  localparam logic [63:0]     HALF_PI_Q30 = 64'd1686629713;
  localparam logic [31:0]     DEG90_Q20   = 32'd94371840;
  localparam logic [T_W-1:0]  DIV45_MULT  = 21'd1491309;
  localparam int              DIV45_SHIFT = 26;
  localparam logic [24:0]     METRE_SCALE = 25'd28465901;
  localparam logic [SQ_W-1:0] SQ_MAX      = {SQ_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
  localparam logic [63:0]     TAYLOR_DIV [1:10] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                                    64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_REF_LON = 1'b0,
    CFG_REF_LAT = 1'b1
  } npe_cfg_idx_t;

  // One finished set handed from front to back
  typedef struct packed {
    logic [POS_W-1:0] best_pos;
    logic [SQ_W-1:0]  best_sq;
  } npe_set_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROOT,
    BK_SCALE,
    BK_ROUND,
    BK_OUT
  } npe_back_state_t;

endpackage

[rtl/nearest_point_equirectangular.sv]
// Throughput: one point per cycle, while the set queue is not full, through the
// eight-stage distance pipeline; the square-root sequencer takes one set result
// at a time, and a two-entry set queue absorbs short sets before input stalls.
// Reset: synchronous, active low; clears pipeline, best-so-far, queue and
// reference registers (reference position returns to zero).
`timescale 1ns / 1ps
module nearest_point_equirectangular
  import npe_pkg::*;
#(
  parameter int MAX_POINTS        = MAX_POINTS_DEF,
  parameter int COS_TABLE_ENTRIES = COS_TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // point_longitude[28:0], point_latitude[56:29]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // best_position[15:0], best_distance_m[41:16]
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [28:0] cfg_wdata
);

  logic [LON_W-1:0] ref_lon_r;
  logic [LAT_W-1:0] ref_lat_r;
  logic             pipe_en;
  logic             set_push;
  npe_set_t         set_data;
  npe_set_t         q_data;
  logic             q_full, q_empty, q_pop;
  logic [POS_W-1:0] out_pos;
  logic [DIST_W-1:0] out_dist;

  // Reference position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lon_r <= '0;
      ref_lat_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (npe_cfg_idx_t'(cfg_index))
        CFG_REF_LON: ref_lon_r <= cfg_wdata[LON_W-1:0];
        CFG_REF_LAT: ref_lat_r <= cfg_wdata[LAT_W-1:0];
        default:     ;
      endcase
    end
  end

  // Hold the whole front pipeline while the set queue is full
  assign pipe_en   = !q_full;
  assign in_tready = pipe_en;

  npe_front #(
    .MAX_POINTS        (MAX_POINTS),
    .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (in_tvalid),
    .pt_lon   (in_tdata[LON_W-1:0]),
    .pt_lat   (in_tdata[LON_W+LAT_W-1:LON_W]),
    .pt_last  (in_tlast),
    .ref_lon  (ref_lon_r),
    .ref_lat  (ref_lat_r),
    .set_push (set_push),
    .set_data (set_data)
  );

  npe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (set_push),
    .push_data (set_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  npe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_pos  (out_pos),
    .out_dist (out_dist)
  );

  assign out_tdata = {6'd0, out_dist, out_pos};

endmodule

[rtl/npe_fifo.sv]
// Short queue of finished sets between front and back.
`timescale 1ns / 1ps
module npe_fifo
  import npe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  npe_set_t push_data,
  input  logic     pop,
  output npe_set_t pop_data,
  output logic     full,
  output logic     empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  npe_set_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]       count_r, count_nxt;

  assign full     = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Advance pointers, wrapping at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/npe_front.sv]
// Distance pipeline and compare-and-keep for the nearest-point search.
`timescale 1ns / 1ps
module npe_front
  import npe_pkg::*;
#(
  parameter int MAX_POINTS        = MAX_POINTS_DEF,
  parameter int COS_TABLE_ENTRIES = COS_TABLE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [LON_W-1:0] pt_lon,
  input  logic [LAT_W-1:0] pt_lat,
  input  logic             pt_last,
  input  logic [LON_W-1:0] ref_lon,
  input  logic [LAT_W-1:0] ref_lat,
  output logic             set_push,
  output npe_set_t         set_data
);

  localparam int CNT_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int IDX_W = $clog2(COS_TABLE_ENTRIES + 1);
  localparam int P1_W  = LAT_W + 1 + IDX_W;

  typedef logic [COS_W-1:0] cos_rom_t [COS_TABLE_ENTRIES+1];

  // Cosine table in Q1.16 from a Taylor series, built at elaboration
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t    rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] q;
    longint      sum;
    for (int k = 0; k <= COS_TABLE_ENTRIES; k++) begin
      x    = (64'(k) * HALF_PI_Q30 + 64'(COS_TABLE_ENTRIES / 2)) / COS_TABLE_ENTRIES;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      q = (64'(sum) + 64'd8192) >> 14;
      if (q > 64'd65536) begin
        q = 64'd65536;
      end
      rom[k] = COS_W'(q);
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

  // Stage 1: differences and latitude sum
  logic                    s1_vld_r, s1_last_r;
  logic [LON_W:0]          s1_adlon_r;
  logic [LAT_W:0]          s1_adlat_r;
  logic [LAT_W:0]          s1_asum_r;
  logic signed [LON_W:0]   dlon;
  logic signed [LAT_W:0]   dlat;
  logic signed [LAT_W:0]   slat;

  assign dlon = signed'({pt_lon[LON_W-1], pt_lon}) - signed'({ref_lon[LON_W-1], ref_lon});
  assign dlat = signed'({pt_lat[LAT_W-1], pt_lat}) - signed'({ref_lat[LAT_W-1], ref_lat});
  assign slat = signed'({pt_lat[LAT_W-1], pt_lat}) + signed'({ref_lat[LAT_W-1], ref_lat});

  // Stage 2..8 registers
  logic                    s2_vld_r, s2_last_r;
  logic [LON_W:0]          s2_adlon_r;
  logic [LAT_W:0]          s2_adlat_r;
  logic [P1_W-1:0]         s2_p1_r;
  logic                    s3_vld_r, s3_last_r;
  logic [LON_W:0]          s3_adlon_r;
  logic [LAT_W:0]          s3_adlat_r;
  logic [2*T_W-1:0]        s3_p2_r;
  logic                    s4_vld_r, s4_last_r;
  logic [LON_W:0]          s4_adlon_r;
  logic [LAT_W:0]          s4_adlat_r;
  logic [COS_W-1:0]        s4_cos_r;
  logic                    s5_vld_r, s5_last_r;
  logic [LAT_W:0]          s5_adlat_r;
  logic [LON_W+COS_W:0]    s5_p3_r;
  logic                    s6_vld_r, s6_last_r;
  logic [25:0]             s6_dx_r;
  logic [24:0]             s6_dy_r;
  logic                    s7_vld_r, s7_last_r;
  logic [51:0]             s7_dx2_r;
  logic [49:0]             s7_dy2_r;
  logic                    s8_vld_r, s8_last_r;
  logic [SQ_W-1:0]         s8_sq_r;

  logic [T_W-1:0]          t_val;
  logic [2*T_W-DIV45_SHIFT-1:0] idx_raw;
  logic [IDX_W-1:0]        idx;
  logic [LON_W+COS_W+1:0]  dx_sum;
  logic [52:0]             sq_sum;

  // Index of the mean-latitude cosine, capped at the last entry
  assign t_val   = T_W'(({1'b0, s2_p1_r} + (P1_W+1)'(DEG90_Q20)) >> 22);
  assign idx_raw = s3_p2_r[2*T_W-1:DIV45_SHIFT];
  assign idx     = (idx_raw > (2*T_W-DIV45_SHIFT)'(COS_TABLE_ENTRIES)) ?
                   IDX_W'(COS_TABLE_ENTRIES) : IDX_W'(idx_raw);
  assign dx_sum  = {1'b0, s5_p3_r} + (LON_W+COS_W+2)'(1 << 20);
  assign sq_sum  = 53'(s7_dx2_r) + 53'(s7_dy2_r);

  // Valid bits through the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
      s8_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
      s8_vld_r <= s7_vld_r;
    end
  end

  // Payload through the pipeline; cosine table read is registered
  always_ff @(posedge clk) begin
    if (en) begin
      s1_last_r  <= pt_last;
      s1_adlon_r <= dlon[LON_W] ? (LON_W+1)'(-dlon) : (LON_W+1)'(dlon);
      s1_adlat_r <= dlat[LAT_W] ? (LAT_W+1)'(-dlat) : (LAT_W+1)'(dlat);
      s1_asum_r  <= slat[LAT_W] ? (LAT_W+1)'(-slat) : (LAT_W+1)'(slat);

      s2_last_r  <= s1_last_r;
      s2_adlon_r <= s1_adlon_r;
      s2_adlat_r <= s1_adlat_r;
      s2_p1_r    <= P1_W'(s1_asum_r) * P1_W'(COS_TABLE_ENTRIES);

      s3_last_r  <= s2_last_r;
      s3_adlon_r <= s2_adlon_r;
      s3_adlat_r <= s2_adlat_r;
      s3_p2_r    <= (2*T_W)'(t_val) * (2*T_W)'(DIV45_MULT);

      s4_last_r  <= s3_last_r;
      s4_adlon_r <= s3_adlon_r;
      s4_adlat_r <= s3_adlat_r;
      s4_cos_r   <= COS_ROM[idx];

      s5_last_r  <= s4_last_r;
      s5_adlat_r <= s4_adlat_r;
      s5_p3_r    <= (LON_W+COS_W+1)'(s4_adlon_r) * (LON_W+COS_W+1)'(s4_cos_r);

      s6_last_r  <= s5_last_r;
      s6_dx_r    <= 26'(dx_sum >> 21);
      s6_dy_r    <= 25'(((LAT_W+2)'(s5_adlat_r) + (LAT_W+2)'(16)) >> 5);

      s7_last_r  <= s6_last_r;
      s7_dx2_r   <= 52'(s6_dx_r) * 52'(s6_dx_r);
      s7_dy2_r   <= 50'(s6_dy_r) * 50'(s6_dy_r);

      s8_last_r  <= s7_last_r;
      s8_sq_r    <= (sq_sum > 53'(SQ_MAX)) ? SQ_MAX : SQ_W'(sq_sum);
    end
  end

  // Compare and keep: a strictly smaller distance takes over
  logic [CNT_W-1:0] item_cnt_r, item_cnt_nxt;
  logic [SQ_W-1:0]  best_sq_r, best_sq_nxt;
  logic [CNT_W-1:0] best_idx_r, best_idx_nxt;
  logic             better;
  logic [SQ_W-1:0]  cur_sq;
  logic [CNT_W-1:0] cur_idx;

  assign better  = (s8_sq_r < best_sq_r);
  assign cur_sq  = better ? s8_sq_r : best_sq_r;
  assign cur_idx = better ? item_cnt_r : best_idx_r;

  assign set_push          = en && s8_vld_r && s8_last_r;
  assign set_data.best_pos = POS_W'(cur_idx);
  assign set_data.best_sq  = cur_sq;

  always_comb begin
    item_cnt_nxt = item_cnt_r;
    best_sq_nxt  = best_sq_r;
    best_idx_nxt = best_idx_r;
    if (en && s8_vld_r) begin
      if (s8_last_r) begin
        item_cnt_nxt = '0;
        best_sq_nxt  = SQ_MAX;
        best_idx_nxt = '0;
      end else begin
        item_cnt_nxt = (item_cnt_r == CNT_W'(MAX_POINTS - 1)) ? '0 : item_cnt_r + 1'b1;
        best_sq_nxt  = cur_sq;
        best_idx_nxt = cur_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_cnt_r <= '0;
      best_sq_r  <= SQ_MAX;
      best_idx_r <= '0;
    end else begin
      item_cnt_r <= item_cnt_nxt;
      best_sq_r  <= best_sq_nxt;
      best_idx_r <= best_idx_nxt;
    end
  end

endmodule

[rtl/npe_back.sv]
// Square root, metre scaling and output register for finished sets.
`timescale 1ns / 1ps
module npe_back
  import npe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  npe_set_t          q_data,
  output logic              q_pop,
  output logic              out_vld,
  input  logic              out_rdy,
  output logic [POS_W-1:0]  out_pos,
  output logic [DIST_W-1:0] out_dist
);

  npe_back_state_t  state_r, state_nxt;
  logic [4:0]       step_r;
  logic [63:0]      rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [56:0]      prod_r;
  logic [POS_W-1:0] pos_r;
  logic [DIST_W-1:0] dist_r;

  logic [63:0]      bit_val;
  logic [63:0]      trial;
  logic [57:0]      rounded;
  logic [26:0]      metres;

  assign bit_val = 64'd1 << (6'd62 - {step_r, 1'b0});
  assign trial   = root_r + bit_val;
  assign rounded = {1'b0, prod_r} + 58'(1 << 30);
  assign metres  = rounded[57:31];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (!q_empty) state_nxt = BK_ROOT;
      BK_ROOT:  if (step_r == 5'd31) state_nxt = BK_SCALE;
      BK_SCALE: state_nxt = BK_ROUND;
      BK_ROUND: state_nxt = BK_OUT;
      BK_OUT:   if (out_rdy) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    q_pop   = 1'b0;
    out_vld = 1'b0;
    unique case (state_r)
      BK_IDLE:  q_pop = !q_empty;
      BK_OUT:   out_vld = 1'b1;
      default:  ;
    endcase
  end

  assign out_pos  = pos_r;
  assign out_dist = dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Restoring square root, one result bit a cycle, then scale and round
  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        rem_r  <= {q_data.best_sq, 16'd0};
        root_r <= '0;
        step_r <= '0;
        pos_r  <= q_data.best_pos;
      end
      BK_ROOT: begin
        if (rem_r >= trial) begin
          rem_r  <= rem_r - trial;
          root_r <= (root_r >> 1) + bit_val;
        end else begin
          root_r <= root_r >> 1;
        end
        step_r <= step_r + 1'b1;
      end
      BK_SCALE: prod_r <= 57'(root_r[31:0]) * 57'(METRE_SCALE);
      BK_ROUND: dist_r <= (metres > 27'(DIST_MAX)) ? DIST_MAX : DIST_W'(metres);
      BK_OUT:   ;
      default:  ;
    endcase
  end

endmodule
